### design/html_escape_encoder_core_assert.svh
// Assertion macros used by the escape encoder back end.
`ifndef HTML_ESCAPE_ENCODER_CORE_ASSERT_SVH
`define HTML_ESCAPE_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/html_esc_pkg.sv
// Types, character constants and the classification function of the escape encoder.
`timescale 1ns / 1ps
`default_nettype none

package html_esc_pkg;

	localparam int CP_W      = 21;
	localparam int MAX_CHARS = 6;
	localparam int LEN_W     = 3;

	localparam logic [CP_W-1:0] CH_QUOT  = 21'h22;
	localparam logic [CP_W-1:0] CH_HASH  = 21'h23;
	localparam logic [CP_W-1:0] CH_AMP   = 21'h26;
	localparam logic [CP_W-1:0] CH_APOS  = 21'h27;
	localparam logic [CP_W-1:0] CH_SLASH = 21'h2F;
	localparam logic [CP_W-1:0] CH_ZERO  = 21'h30;
	localparam logic [CP_W-1:0] CH_NINE  = 21'h39;
	localparam logic [CP_W-1:0] CH_SEMI  = 21'h3B;
	localparam logic [CP_W-1:0] CH_LT    = 21'h3C;
	localparam logic [CP_W-1:0] CH_GT    = 21'h3E;
	localparam logic [CP_W-1:0] CH_UP_A  = 21'h41;
	localparam logic [CP_W-1:0] CH_UP_F  = 21'h46;
	localparam logic [CP_W-1:0] CH_UP_Z  = 21'h5A;
	localparam logic [CP_W-1:0] CH_LO_A  = 21'h61;
	localparam logic [CP_W-1:0] CH_LO_G  = 21'h67;
	localparam logic [CP_W-1:0] CH_LO_L  = 21'h6C;
	localparam logic [CP_W-1:0] CH_LO_M  = 21'h6D;
	localparam logic [CP_W-1:0] CH_LO_O  = 21'h6F;
	localparam logic [CP_W-1:0] CH_LO_P  = 21'h70;
	localparam logic [CP_W-1:0] CH_LO_Q  = 21'h71;
	localparam logic [CP_W-1:0] CH_LO_T  = 21'h74;
	localparam logic [CP_W-1:0] CH_LO_U  = 21'h75;
	localparam logic [CP_W-1:0] CH_LO_X  = 21'h78;
	localparam logic [CP_W-1:0] CH_LO_Z  = 21'h7A;
	localparam logic [CP_W-1:0] CH_TWO   = 21'h32;
	localparam logic [CP_W-1:0] CH_SEVEN = 21'h37;
	localparam logic [CP_W-1:0] CP_HIGH  = 21'hFF;

	// One classified item: the characters it expands to and how many there are.
	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic [MAX_CHARS-1:0][CP_W-1:0]  chars;
	} esc_desc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [CP_W-1:0] digit_char(input logic [3:0] d);
		return CH_ZERO | {17'd0, d};
	endfunction

	function automatic esc_desc_t build_desc(input logic [CP_W-1:0] c, input logic en);
		esc_desc_t         d;
		logic              alnum;
		logic [7:0]        v;
		logic [1:0]        hund;
		logic [6:0]        rem;
		logic [13:0]       prod;
		logic [3:0]        tens;
		logic [3:0]        ones;
		d     = '0;
		alnum = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
			(c >= CH_LO_A && c <= CH_LO_Z);
		v     = c[7:0];
		hund  = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		rem   = 7'(v - 8'(hund) * 8'd100);
		// Multiply by 103/1024 gives the exact quotient by ten for values below 100.
		prod  = 14'(rem) * 14'd103;
		tens  = prod[13:10];
		ones  = 4'(rem - 7'(tens) * 7'd10);
		if (!en || alnum || c >= CP_HIGH) begin
			d.len      = 3'd1;
			d.chars[0] = c;
		end else if (c == CH_AMP) begin
			d.len   = 3'd5;
			d.chars = {CH_GT, CH_SEMI, CH_LO_P, CH_LO_M, CH_LO_A, CH_AMP};
		end else if (c == CH_LT) begin
			d.len   = 3'd4;
			d.chars = {CH_GT, CH_GT, CH_SEMI, CH_LO_T, CH_LO_L, CH_AMP};
		end else if (c == CH_GT) begin
			d.len   = 3'd4;
			d.chars = {CH_GT, CH_GT, CH_SEMI, CH_LO_T, CH_LO_G, CH_AMP};
		end else if (c == CH_QUOT) begin
			d.len   = 3'd6;
			d.chars = {CH_SEMI, CH_LO_T, CH_LO_O, CH_LO_U, CH_LO_Q, CH_AMP};
		end else if (c == CH_APOS) begin
			d.len   = 3'd6;
			d.chars = {CH_SEMI, CH_SEVEN, CH_TWO, CH_LO_X, CH_HASH, CH_AMP};
		end else if (c == CH_SLASH) begin
			d.len   = 3'd6;
			d.chars = {CH_SEMI, CH_UP_F, CH_TWO, CH_LO_X, CH_HASH, CH_AMP};
		end else begin
			d.chars[0] = CH_AMP;
			d.chars[1] = CH_HASH;
			if (v >= 8'd100) begin
				d.len      = 3'd6;
				d.chars[2] = digit_char({2'b00, hund});
				d.chars[3] = digit_char(tens);
				d.chars[4] = digit_char(ones);
				d.chars[5] = CH_SEMI;
			end else if (v >= 8'd10) begin
				d.len      = 3'd5;
				d.chars[2] = digit_char(tens);
				d.chars[3] = digit_char(ones);
				d.chars[4] = CH_SEMI;
			end else begin
				d.len      = 3'd4;
				d.chars[2] = digit_char(ones);
				d.chars[3] = CH_SEMI;
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

### design/html_esc_front.sv
// Front end: accepts code points and classifies each into its output character list.
`timescale 1ns / 1ps
`default_nettype none

module html_esc_front import html_esc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             escape_enable,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [CP_W-1:0]  code_point,
	input  wire q_status_t        q_status,
	output logic                  push,
	output esc_desc_t             push_desc
);

	logic      valid_s1;
	esc_desc_t desc_s1;
	logic      accept;

	assign in_stall  = valid_s1 && q_status.full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_status.full;
	assign push_desc = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= build_desc(code_point, escape_enable);
		end
	end

endmodule

`default_nettype wire

### design/html_esc_queue.sv
// Small register queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module html_esc_queue import html_esc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire esc_desc_t  push_desc,
	input  wire logic       pop,
	output esc_desc_t       head,
	output q_status_t       status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	esc_desc_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CW'(DEPTH));
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

### design/html_esc_back.sv
// Back end: walks each queued item's characters out, one beat per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "html_escape_encoder_core_assert.svh"

module html_esc_back import html_esc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire esc_desc_t        head,
	input  wire q_status_t        q_status,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [CP_W-1:0]       out_char,
	output logic                  last
);

	logic [LEN_W-1:0] idx_q;
	logic             out_valid_q;
	logic [CP_W-1:0]  out_char_q;
	logic             last_q;
	logic             can_load;
	logic             take;
	logic             head_last;

	assign can_load  = !out_valid_q || !out_stall;
	assign take      = can_load && !q_status.empty;
	assign head_last = (idx_q == LEN_W'(head.len - 1'b1));
	assign pop       = take && head_last;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= head_last ? '0 : LEN_W'(idx_q + 1'b1);
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q <= head.chars[idx_q];
			last_q     <= head_last;
		end
	end

	// The character index never runs past the length of the item at the head.
	`ESC_ASSERT_IMP(a_idx_in_range, clk, arst_n, !q_status.empty, idx_q < head.len, "index past item length")
	// A partly sent item keeps its place at the head of the queue.
	`ESC_ASSERT_IMP(a_mid_item_queued, clk, arst_n, idx_q != '0, !q_status.empty, "item lost mid sequence")
	// Once a non-final beat is taken, the next character of the same item follows at once.
	`ESC_ASSERT_NXT(a_no_gap, clk, arst_n, out_valid_q && !out_stall && !last_q, out_valid_q, "gap inside an expansion")

endmodule

`default_nettype wire

### design/html_escape_encoder_core.sv
// Top level of the HTML entity escape encoder.
`timescale 1ns / 1ps
`default_nettype none

// One code point enters per beat and leaves as one or more output characters, the final one
// marked by last. With escape_enable low, or for letters, digits and code points of 0xFF and
// above, an item yields one character and items stream at one per cycle unless stalled. Escaped
// items expand to four to six characters (named, hex or decimal entities), which the back end
// sends one per cycle unless stalled; the front end keeps accepting into a QUEUE_DEPTH-entry
// queue meanwhile. Each item passes the front-end register, the queue and the output register.
// The user writes escape_enable via cfg_wr_en/cfg_wr_data only while idle, unenforced by the block.
module html_escape_encoder_core import html_esc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic             cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [CP_W-1:0]  code_point,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [CP_W-1:0]       out_char,
	output logic                  last
);

	logic      escape_enable_q;
	logic      push;
	logic      pop;
	esc_desc_t push_desc;
	esc_desc_t head;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			escape_enable_q <= cfg_wr_data;
		end
	end

	html_esc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.escape_enable (escape_enable_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_point    (code_point),
		.q_status      (q_status),
		.push          (push),
		.push_desc     (push_desc)
	);

	html_esc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	html_esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last      (last)
	);

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the HTML entity escape encoder core.
`timescale 1ns / 1ps

module tb;
	import html_esc_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [CP_W-1:0] ch;
		logic            last;
	} out_beat_t;

	// Predicts the character sequence of each accepted code point and checks output beats
	// against it in order.
	class char_scoreboard;
		bit          escape_en;
		out_beat_t   expected_chars[$];
		int unsigned errors;
		int unsigned n_items;
		int unsigned n_chars;
		int unsigned n_expanded;

		function int pending();
			return expected_chars.size();
		endfunction

		function void note_code_point(input logic [CP_W-1:0] cp);
			string     text;
			bit        alnum;
			out_beat_t beat;
			n_items++;
			alnum = (cp >= CH_ZERO && cp <= CH_NINE) || (cp >= CH_UP_A && cp <= CH_UP_Z) ||
				(cp >= CH_LO_A && cp <= CH_LO_Z);
			if (!escape_en || alnum || cp >= CP_HIGH) begin
				beat.ch   = cp;
				beat.last = 1'b1;
				expected_chars.push_back(beat);
			end else begin
				case (cp)
					CH_AMP:   text = "&amp;";
					CH_LT:    text = "&lt;";
					CH_GT:    text = "&gt;";
					CH_QUOT:  text = "&quot;";
					CH_APOS:  text = "&#x27;";
					CH_SLASH: text = "&#x2F;";
					default:  text = $sformatf("&#%0d;", cp);
				endcase
				n_expanded++;
				for (int i = 0; i < text.len(); i++) begin
					beat.ch       = '0;
					beat.ch[7:0]  = text[i];
					beat.last     = (i == text.len() - 1);
					expected_chars.push_back(beat);
				end
			end
		endfunction

		function void check_char(input logic [CP_W-1:0] ch, input logic lst);
			out_beat_t want;
			n_chars++;
			if (expected_chars.size() == 0) begin
				$error("out_char: no character expected, got %h (last %0b)", ch, lst);
				errors++;
			end else begin
				want = expected_chars.pop_front();
				if (ch !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, ch);
					errors++;
				end
				if (lst !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, lst);
					errors++;
				end
			end
		endfunction
	endclass

	localparam logic [CP_W-1:0] SPECIALS [6] = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS,
		CH_SLASH};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wr_en = 1'b0;
	logic            cfg_wr_data = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [CP_W-1:0] code_point = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [CP_W-1:0] out_char;
	logic            last;

	char_scoreboard sb = new();
	bit             hold_off_req = 1'b0;
	int unsigned    hold_offs = 0;
	int unsigned    cfg_writes = 0;
	int unsigned    cycles = 0;

	html_escape_encoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last       (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both channels are observed in one place so an input beat is always noted before any
	// output beat of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_code_point(code_point);
			if (out_valid && !out_stall)
				sb.check_char(out_char, last);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters outstanding", cycles,
				sb.pending());
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: stall behavior changes every so often; a hold-off request freezes the output.
	initial begin : receiver
		int mode;
		int left;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			left = $urandom_range(20, 150);
			while (left > 0) begin
				@(negedge clk);
				if (hold_off_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_offs++;
					hold_off_req = 1'b0;
				end else begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 99) < 30);
						2: out_stall <= ($urandom_range(0, 99) < 70);
						default: out_stall <= (left % 4 == 0);
					endcase
				end
				left--;
			end
		end
	end

	task automatic send_cp(input logic [CP_W-1:0] cp);
		@(negedge clk);
		in_valid   <= 1'b1;
		code_point <= cp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle(input int n);
		@(negedge clk);
		in_valid   <= 1'b0;
		code_point <= CP_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_escape(input bit en);
		wait_drained();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= en;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sb.escape_en = en;
		cfg_writes++;
	endtask

	function automatic logic [CP_W-1:0] random_cp();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return CP_W'($urandom_range(0, 'h7F));
			4, 5:       return CP_W'($urandom_range('h80, 'h1FF));
			6:          return SPECIALS[$urandom_range(0, 5)];
			7, 8:       return CP_W'($urandom);
			default:    return CP_W'($urandom_range(0, 'hFF));
		endcase
	endfunction

	// Bursts of random length; gaps between them unless the caller wants a continuous stream.
	task automatic send_bursts(input int total, input bit gapless);
		int sent;
		int len;
		sent = 0;
		while (sent < total) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len && sent < total; i++) begin
				send_cp(random_cp());
				sent++;
			end
			if (!gapless && $urandom_range(0, 2) != 0)
				idle($urandom_range(1, 10));
		end
	endtask

	initial begin : stimulus
		logic [CP_W-1:0] plain_list [3];
		logic [CP_W-1:0] escaped_list [22];
		plain_list   = '{21'h00, CH_AMP, 21'h1FFFFF};
		escaped_list = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_SLASH,
			21'h00, 21'h09, 21'h0A, 21'h40, 21'h5B, 21'h60, 21'h7B, 21'hC8, 21'hFE,
			CP_HIGH, CH_ZERO, CH_NINE, CH_UP_Z, CH_LO_Z, 21'h10FFFF, 21'h1FFFFF};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Escaping is off after reset: everything passes through.
		foreach (plain_list[i])
			send_cp(plain_list[i]);

		write_escape(1'b1);
		foreach (escaped_list[i])
			send_cp(escaped_list[i]);

		send_bursts(100, 1'b0);

		write_escape(1'b0);
		send_bursts(60, 1'b0);

		write_escape(1'b1);
		send_bursts(40, 1'b0);
		// Freeze the output while a continuous stream fills the block and backs up its input.
		hold_off_req = 1'b1;
		send_bursts(30, 1'b1);
		wait_drained();
		send_bursts(50, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("last: %0d expected characters never arrived", sb.pending());
			sb.errors++;
		end
		$display("Sent %0d code points (%0d expanded to entities), checked %0d output beats.",
			sb.n_items, sb.n_expanded, sb.n_chars);
		$display("Made %0d escape_enable writes and %0d long output hold-offs in %0d cycles.",
			cfg_writes, hold_offs, cycles);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### html_escape_encoder_core.f
+incdir+design
design/html_esc_pkg.sv
design/html_esc_front.sv
design/html_esc_queue.sv
design/html_esc_back.sv
design/html_escape_encoder_core.sv
tb/sv/tb.sv
